@@ rtl/vertex_skinning_four_bone_assert.svh @@
// ---------------------------------------------------------------------------
// vertex skinning assertion macros
// shared clocked assertion forms, disabled while reset is high
// ---------------------------------------------------------------------------
`ifndef VERTEX_SKINNING_FOUR_BONE_ASSERT_SVH
`define VERTEX_SKINNING_FOUR_BONE_ASSERT_SVH

// same-cycle implication
`define VSK_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vsk assertion failed");

// next-cycle implication
`define VSK_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vsk assertion failed");

`endif

@@ rtl/vsk_pkg.sv @@
// ---------------------------------------------------------------------------
// vsk_pkg
// types, widths and codes shared by the vertex skinning pipeline
// ---------------------------------------------------------------------------
package vsk_pkg;

   localparam int MAX_BONES  = 255;
   localparam int SLOT_W     = 8;
   localparam int COORD_W    = 32;
   localparam int QUAT_W     = 16;
   localparam int QSHIFT     = 14;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int QPROD_W    = 2 * QUAT_W;
   localparam int MFULL_W    = 35;
   localparam int M_W        = MFULL_W - QSHIFT;
   localparam int MPROD_W    = M_W + DIFF_W;
   localparam int XACC_W     = MPROD_W + 2;
   localparam int RS_W       = XACC_W - QSHIFT;
   localparam int R_W        = RS_W + 2;
   localparam int WGT_W      = 8;
   localparam int WPROD_W    = R_W + WGT_W + 1;
   localparam int ACC_W      = WPROD_W + 3;
   localparam int DEN_W      = WGT_W + 2;
   localparam int DIV_W      = 60;
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = DIV_W / DIV_STEP;
   localparam int DIV_LAT    = DIV_STAGES + 1;
   localparam int XF_LAT     = 4;
   localparam int SB_DEPTH   = XF_LAT + 1;

   localparam logic [1:0] CMD_LOAD_BIND = 2'd0;
   localparam logic [1:0] CMD_LOAD_POSE = 2'd1;
   localparam logic [1:0] CMD_SKIN      = 2'd2;

   localparam logic [SLOT_W-1:0]  ABSENT_BONE = 8'hFF;
   localparam logic [COORD_W-1:0] SAT_MAX     = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] SAT_MIN     = 32'h8000_0000;

   typedef struct packed {
      logic [1:0]                command;
      logic [SLOT_W-1:0]         bone_slot;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [QUAT_W-1:0]  quat_w;
      logic signed [QUAT_W-1:0]  quat_x;
      logic signed [QUAT_W-1:0]  quat_y;
      logic signed [QUAT_W-1:0]  quat_z;
      logic [31:0]               bone_ids;
      logic [31:0]               bone_weights;
      logic                      vertex_last;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      out_last;
      logic                      weight_fault;
   } rsp_type;

   // element 0 is x
   typedef logic [2:0][COORD_W-1:0] vec_type;
   typedef logic [2:0][R_W-1:0]     res_type;

   typedef struct packed {
      vec_type                  pos;
      logic signed [QUAT_W-1:0] qw;
      logic signed [QUAT_W-1:0] qx;
      logic signed [QUAT_W-1:0] qy;
      logic signed [QUAT_W-1:0] qz;
   } pose_type;

   typedef struct packed {
      logic        valid;
      logic        last;
      logic [31:0] weights;
      logic [3:0]  used;
   } sb_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic fault;
   } ctl_type;

endpackage

@@ rtl/vsk_bone_mem.sv @@
// ---------------------------------------------------------------------------
// vsk_bone_mem
// one read copy of the bind and pose tables, registered read, zero past range
// ---------------------------------------------------------------------------
module vsk_bone_mem (
   input  logic                         clock,
   input  logic                         bind_we,
   input  logic                         pose_we,
   input  logic [vsk_pkg::SLOT_W-1:0]   wr_addr,
   input  vsk_pkg::vec_type             wr_bind,
   input  vsk_pkg::pose_type            wr_pose,
   input  logic                         rd_en,
   input  logic [vsk_pkg::SLOT_W-1:0]   rd_addr,
   output vsk_pkg::vec_type             rd_bind,
   output vsk_pkg::pose_type            rd_pose
);

   vsk_pkg::vec_type  bind_mem [vsk_pkg::MAX_BONES];
   vsk_pkg::pose_type pose_mem [vsk_pkg::MAX_BONES];
   vsk_pkg::vec_type  bind_rd_ff;
   vsk_pkg::pose_type pose_rd_ff;
   logic              oob_ff;

   always_ff @(posedge clock) begin
      if (bind_we) begin
         bind_mem[wr_addr] <= wr_bind;
      end
      if (pose_we) begin
         pose_mem[wr_addr] <= wr_pose;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         bind_rd_ff <= bind_mem[rd_addr];
         pose_rd_ff <= pose_mem[rd_addr];
         oob_ff     <= 32'(rd_addr) >= 32'(vsk_pkg::MAX_BONES);
      end
   end

   // absent bone reads as zero: identity rotation, zero offsets
   assign rd_bind = oob_ff ? '0 : bind_rd_ff;
   assign rd_pose = oob_ff ? '0 : pose_rd_ff;

endmodule

@@ rtl/vsk_bone_xform.sv @@
// ---------------------------------------------------------------------------
// vsk_bone_xform
// four-stage bone transform: rotation matrix from quaternion, apply, offset
// ---------------------------------------------------------------------------
module vsk_bone_xform (
   input  logic              clock,
   input  logic              adv,
   input  vsk_pkg::vec_type  vtx,
   input  vsk_pkg::vec_type  bind_pos,
   input  vsk_pkg::pose_type pose,
   output vsk_pkg::res_type  res
);

   localparam logic signed [vsk_pkg::MFULL_W-1:0] ONE_Q28 = 35'sh1000_0000;
   localparam logic signed [vsk_pkg::MFULL_W-1:0] HALF_M  = 35'sd8192;
   localparam logic signed [vsk_pkg::XACC_W-1:0]  HALF_A  = 56'sd8192;

   logic signed [vsk_pkg::DIFF_W-1:0]  d_in [3];
   logic signed [vsk_pkg::DIFF_W-1:0]  d1_ff [3];
   logic signed [vsk_pkg::DIFF_W-1:0]  d2_ff [3];
   logic signed [vsk_pkg::QPROD_W-1:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [vsk_pkg::QPROD_W-1:0] wx_ff, wy_ff, wz_ff;
   vsk_pkg::vec_type                   pos1_ff, pos2_ff, pos3_ff;
   logic signed [vsk_pkg::MFULL_W-1:0] mf [9];
   logic signed [vsk_pkg::M_W-1:0]     m_in [9];
   logic signed [vsk_pkg::M_W-1:0]     m_ff [9];
   logic signed [vsk_pkg::MPROD_W-1:0] p_in [9];
   logic signed [vsk_pkg::MPROD_W-1:0] p_ff [9];
   vsk_pkg::res_type                   r_in, r_ff;

   // stage 1: difference and quaternion products
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         d_in[c] = vsk_pkg::DIFF_W'($signed(vtx[c])) - vsk_pkg::DIFF_W'($signed(bind_pos[c]));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff   <= d_in;
         xx_ff   <= pose.qx * pose.qx;
         yy_ff   <= pose.qy * pose.qy;
         zz_ff   <= pose.qz * pose.qz;
         xy_ff   <= pose.qx * pose.qy;
         xz_ff   <= pose.qx * pose.qz;
         yz_ff   <= pose.qy * pose.qz;
         wx_ff   <= pose.qw * pose.qx;
         wy_ff   <= pose.qw * pose.qy;
         wz_ff   <= pose.qw * pose.qz;
         pos1_ff <= pose.pos;
      end
   end

   // stage 2: matrix in Q28, rounded to Q14
   always_comb begin
      mf[0] = ONE_Q28 - ((vsk_pkg::MFULL_W'(yy_ff) + vsk_pkg::MFULL_W'(zz_ff)) <<< 1);
      mf[1] = (vsk_pkg::MFULL_W'(xy_ff) - vsk_pkg::MFULL_W'(wz_ff)) <<< 1;
      mf[2] = (vsk_pkg::MFULL_W'(xz_ff) + vsk_pkg::MFULL_W'(wy_ff)) <<< 1;
      mf[3] = (vsk_pkg::MFULL_W'(xy_ff) + vsk_pkg::MFULL_W'(wz_ff)) <<< 1;
      mf[4] = ONE_Q28 - ((vsk_pkg::MFULL_W'(xx_ff) + vsk_pkg::MFULL_W'(zz_ff)) <<< 1);
      mf[5] = (vsk_pkg::MFULL_W'(yz_ff) - vsk_pkg::MFULL_W'(wx_ff)) <<< 1;
      mf[6] = (vsk_pkg::MFULL_W'(xz_ff) - vsk_pkg::MFULL_W'(wy_ff)) <<< 1;
      mf[7] = (vsk_pkg::MFULL_W'(yz_ff) + vsk_pkg::MFULL_W'(wx_ff)) <<< 1;
      mf[8] = ONE_Q28 - ((vsk_pkg::MFULL_W'(xx_ff) + vsk_pkg::MFULL_W'(yy_ff)) <<< 1);
      for (int k = 0; k < 9; k++) begin
         m_in[k] = vsk_pkg::M_W'($signed(mf[k] + HALF_M) >>> vsk_pkg::QSHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff    <= m_in;
         d2_ff   <= d1_ff;
         pos2_ff <= pos1_ff;
      end
   end

   // stage 3: nine products
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            p_in[r*3+c] = m_ff[r*3+c] * d2_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff    <= p_in;
         pos3_ff <= pos2_ff;
      end
   end

   // stage 4: row sums, rounding, pose offset
   always_comb begin : row_sum
      logic signed [vsk_pkg::XACC_W-1:0] acc;
      logic signed [vsk_pkg::RS_W-1:0]   rs;
      for (int r = 0; r < 3; r++) begin
         acc = vsk_pkg::XACC_W'(p_ff[r*3]) + vsk_pkg::XACC_W'(p_ff[r*3+1])
             + vsk_pkg::XACC_W'(p_ff[r*3+2]) + HALF_A;
         rs  = vsk_pkg::RS_W'(acc >>> vsk_pkg::QSHIFT);
         r_in[r] = vsk_pkg::R_W'(rs) + vsk_pkg::R_W'($signed(pos3_ff[r]));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff <= r_in;
      end
   end

   assign res = r_ff;

endmodule

@@ rtl/vsk_blend.sv @@
// ---------------------------------------------------------------------------
// vsk_blend
// weighted sum of bone results, divisor select, magnitude and rounding bias
// ---------------------------------------------------------------------------
module vsk_blend (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  vsk_pkg::sb_type                sb,
   input  vsk_pkg::res_type               res [4],
   output logic [vsk_pkg::DIV_W-1:0]      num [3],
   output logic [vsk_pkg::DEN_W-1:0]      den,
   output logic [2:0]                     neg,
   output vsk_pkg::ctl_type               ctl
);

   logic [vsk_pkg::WGT_W-1:0]          wm [4];
   vsk_pkg::res_type                   rm [4];
   logic signed [vsk_pkg::WPROD_W-1:0] prod_in [4][3];
   logic signed [vsk_pkg::WPROD_W-1:0] prod_ff [4][3];
   logic [vsk_pkg::DEN_W-1:0]          sum_in, sum_ff;
   logic                               multi_ff;
   vsk_pkg::res_type                   r0_ff;
   vsk_pkg::ctl_type                   ca_in, ca_ff, cb_in, cb_ff, cc_ff;
   logic signed [vsk_pkg::ACC_W-1:0]   val_in [3];
   logic signed [vsk_pkg::ACC_W-1:0]   val_ff [3];
   logic [vsk_pkg::DEN_W-1:0]          den_in, den_ff, denc_ff;
   logic [vsk_pkg::ACC_W-1:0]          mag [3];
   logic [vsk_pkg::DIV_W-1:0]          num_in [3];
   logic [vsk_pkg::DIV_W-1:0]          num_ff [3];
   logic [2:0]                         neg_in, neg_ff;
   logic                               take_r0;

   // stage a: weight products, unused bones weigh zero and their results are dropped
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < 4; i++) begin
         wm[i]  = sb.used[i] ? sb.weights[i*vsk_pkg::WGT_W +: vsk_pkg::WGT_W] : '0;
         rm[i]  = sb.used[i] ? res[i] : '0;
         sum_in = sum_in + vsk_pkg::DEN_W'(wm[i]);
         for (int c = 0; c < 3; c++) begin
            prod_in[i][c] = $signed(rm[i][c]) * $signed({1'b0, wm[i]});
         end
      end
      ca_in = '{valid: sb.valid, last: sb.last, fault: 1'b0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff  <= prod_in;
         sum_ff   <= sum_in;
         multi_ff <= sb.used[1];
         r0_ff    <= res[0];
      end
   end

   // stage b: accumulate; single bone or zero sum passes bone 0 over one
   always_comb begin
      take_r0 = !multi_ff || (sum_ff == '0);
      for (int c = 0; c < 3; c++) begin
         val_in[c] = take_r0 ? vsk_pkg::ACC_W'($signed(r0_ff[c]))
                   : vsk_pkg::ACC_W'(prod_ff[0][c]) + vsk_pkg::ACC_W'(prod_ff[1][c])
                   + vsk_pkg::ACC_W'(prod_ff[2][c]) + vsk_pkg::ACC_W'(prod_ff[3][c]);
      end
      den_in = take_r0 ? vsk_pkg::DEN_W'(1) : sum_ff;
      cb_in  = '{valid: ca_ff.valid, last: ca_ff.last,
                 fault: multi_ff && (sum_ff == '0)};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         val_ff <= val_in;
         den_ff <= den_in;
      end
   end

   // stage c: sign and magnitude, half divisor for round to nearest
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         neg_in[c] = val_ff[c][vsk_pkg::ACC_W-1];
         mag[c]    = neg_in[c] ? vsk_pkg::ACC_W'(-val_ff[c]) : vsk_pkg::ACC_W'(val_ff[c]);
         num_in[c] = vsk_pkg::DIV_W'(mag[c]) + vsk_pkg::DIV_W'(den_ff >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff  <= num_in;
         neg_ff  <= neg_in;
         denc_ff <= den_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff <= '0;
         cb_ff <= '0;
         cc_ff <= '0;
      end else if (adv) begin
         ca_ff <= ca_in;
         cb_ff <= cb_in;
         cc_ff <= cb_ff;
      end
   end

   assign num = num_ff;
   assign den = denc_ff;
   assign neg = neg_ff;
   assign ctl = cc_ff;

endmodule

@@ rtl/vsk_divider.sv @@
// ---------------------------------------------------------------------------
// vsk_divider
// pipelined restoring divide, four quotient bits a stage, signed saturation
// ---------------------------------------------------------------------------
module vsk_divider (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [vsk_pkg::DIV_W-1:0]     num,
   input  logic [vsk_pkg::DEN_W-1:0]     den,
   input  logic                          neg,
   output logic [vsk_pkg::COORD_W-1:0]   quo
);

   localparam int NS = vsk_pkg::DIV_STAGES;

   logic [vsk_pkg::DEN_W-1:0] rem_src [NS];
   logic [vsk_pkg::DIV_W-1:0] qn_src [NS];
   logic [vsk_pkg::DEN_W-1:0] dn_src [NS];
   logic                      ng_src [NS];
   logic [vsk_pkg::DEN_W-1:0] rem_in [NS];
   logic [vsk_pkg::DIV_W-1:0] qn_in [NS];
   logic [vsk_pkg::DEN_W-1:0] rem_ff [NS];
   logic [vsk_pkg::DIV_W-1:0] qn_ff [NS];
   logic [vsk_pkg::DEN_W-1:0] dn_ff [NS];
   logic                      ng_ff [NS];
   logic [vsk_pkg::DIV_W-1:0] q;
   logic [vsk_pkg::COORD_W-1:0] quo_in, quo_ff;

   always_comb begin
      rem_src[0] = '0;
      qn_src[0]  = num;
      dn_src[0]  = den;
      ng_src[0]  = neg;
      for (int s = 1; s < NS; s++) begin
         rem_src[s] = rem_ff[s-1];
         qn_src[s]  = qn_ff[s-1];
         dn_src[s]  = dn_ff[s-1];
         ng_src[s]  = ng_ff[s-1];
      end
   end

   // dividend bits shift out the top of qn while quotient bits enter below
   always_comb begin : div_steps
      logic [vsk_pkg::DEN_W:0]   trial;
      logic [vsk_pkg::DEN_W-1:0] rem;
      logic [vsk_pkg::DIV_W-1:0] qn;
      for (int s = 0; s < NS; s++) begin
         rem = rem_src[s];
         qn  = qn_src[s];
         for (int k = 0; k < vsk_pkg::DIV_STEP; k++) begin
            trial = {rem, qn[vsk_pkg::DIV_W-1]};
            qn    = {qn[vsk_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dn_src[s]}) begin
               trial = trial - {1'b0, dn_src[s]};
               qn[0] = 1'b1;
            end
            rem = trial[vsk_pkg::DEN_W-1:0];
         end
         rem_in[s] = rem;
         qn_in[s]  = qn;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         qn_ff  <= qn_in;
         dn_ff  <= dn_src;
         ng_ff  <= ng_src;
      end
   end

   always_comb begin
      q = qn_ff[NS-1];
      if (!ng_ff[NS-1]) begin
         quo_in = (q > vsk_pkg::DIV_W'(vsk_pkg::SAT_MAX)) ? vsk_pkg::SAT_MAX
                : q[vsk_pkg::COORD_W-1:0];
      end else begin
         quo_in = (q > vsk_pkg::DIV_W'(vsk_pkg::SAT_MIN)) ? vsk_pkg::SAT_MIN
                : ~q[vsk_pkg::COORD_W-1:0] + vsk_pkg::COORD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

@@ rtl/vertex_skinning_four_bone.sv @@
// ---------------------------------------------------------------------------
// vertex_skinning_four_bone
// throughput: one word per cycle while the output is not stalled; four bone paths,
// each with its own table copy, and a 15-stage divider keep every stage busy each cycle
// reset: synchronous, clears all stage valid bits, no input taken; tables kept
// ---------------------------------------------------------------------------
module vertex_skinning_four_bone (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vsk_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vsk_pkg::rsp_type rsp_data
);

`include "vertex_skinning_four_bone_assert.svh"

   logic              adv, accept, slot_ok, bind_we, pose_we;
   vsk_pkg::vec_type  wr_bind, v_ff;
   vsk_pkg::pose_type wr_pose;
   vsk_pkg::vec_type  rd_bind [4];
   vsk_pkg::pose_type rd_pose [4];
   vsk_pkg::res_type  res [4];
   vsk_pkg::sb_type   sb_in;
   vsk_pkg::sb_type   sb_ff [vsk_pkg::SB_DEPTH];
   vsk_pkg::ctl_type  blend_ctl;
   vsk_pkg::ctl_type  ctl_ff [vsk_pkg::DIV_LAT];
   logic [vsk_pkg::DIV_W-1:0]   num [3];
   logic [vsk_pkg::DEN_W-1:0]   den;
   logic [2:0]                  neg;
   logic [vsk_pkg::COORD_W-1:0] quo [3];
   logic [7:0]                  ids [4];
   logic [vsk_pkg::SB_DEPTH-1:0] sb_vld;

   // whole pipe moves whenever the output register can take a word
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv && !reset;
   assign accept    = req_valid && req_ready;
   assign slot_ok   = 32'(req_data.bone_slot) < 32'(vsk_pkg::MAX_BONES);
   assign bind_we   = accept && slot_ok && (req_data.command == vsk_pkg::CMD_LOAD_BIND);
   assign pose_we   = accept && slot_ok && (req_data.command == vsk_pkg::CMD_LOAD_POSE);

   assign wr_bind = {req_data.pos_z, req_data.pos_y, req_data.pos_x};
   assign wr_pose = '{pos: wr_bind, qw: req_data.quat_w, qx: req_data.quat_x,
                      qy: req_data.quat_y, qz: req_data.quat_z};

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ids[i] = req_data.bone_ids[i*8 +: 8];
      end
      sb_in.valid   = accept && (req_data.command == vsk_pkg::CMD_SKIN);
      sb_in.last    = req_data.vertex_last;
      sb_in.weights = req_data.bone_weights;
      sb_in.used[0] = 1'b1;
      sb_in.used[1] = ids[1] != vsk_pkg::ABSENT_BONE;
      sb_in.used[2] = sb_in.used[1] && (ids[2] != vsk_pkg::ABSENT_BONE);
      sb_in.used[3] = sb_in.used[2] && (ids[3] != vsk_pkg::ABSENT_BONE);
   end

   for (genvar b = 0; b < 4; b++) begin : g_bone
      vsk_bone_mem u_mem (
         .clock   (clock),
         .bind_we (bind_we),
         .pose_we (pose_we),
         .wr_addr (req_data.bone_slot),
         .wr_bind (wr_bind),
         .wr_pose (wr_pose),
         .rd_en   (adv),
         .rd_addr (ids[b]),
         .rd_bind (rd_bind[b]),
         .rd_pose (rd_pose[b])
      );
      vsk_bone_xform u_xform (
         .clock    (clock),
         .adv      (adv),
         .vtx      (v_ff),
         .bind_pos (rd_bind[b]),
         .pose     (rd_pose[b]),
         .res      (res[b])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff <= wr_bind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < vsk_pkg::SB_DEPTH; s++) begin
            sb_ff[s] <= '0;
         end
      end else if (adv) begin
         sb_ff[0] <= sb_in;
         for (int s = 1; s < vsk_pkg::SB_DEPTH; s++) begin
            sb_ff[s] <= sb_ff[s-1];
         end
      end
   end

   vsk_blend u_blend (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .sb    (sb_ff[vsk_pkg::SB_DEPTH-1]),
      .res   (res),
      .num   (num),
      .den   (den),
      .neg   (neg),
      .ctl   (blend_ctl)
   );

   for (genvar c = 0; c < 3; c++) begin : g_div
      vsk_divider u_div (
         .clock (clock),
         .adv   (adv),
         .num   (num[c]),
         .den   (den),
         .neg   (neg[c]),
         .quo   (quo[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < vsk_pkg::DIV_LAT; s++) begin
            ctl_ff[s] <= '0;
         end
      end else if (adv) begin
         ctl_ff[0] <= blend_ctl;
         for (int s = 1; s < vsk_pkg::DIV_LAT; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   assign rsp_valid = ctl_ff[vsk_pkg::DIV_LAT-1].valid;
   assign rsp_data  = '{out_x: quo[0], out_y: quo[1], out_z: quo[2],
                        out_last: ctl_ff[vsk_pkg::DIV_LAT-1].last,
                        weight_fault: ctl_ff[vsk_pkg::DIV_LAT-1].fault};

   always_comb begin
      for (int s = 0; s < vsk_pkg::SB_DEPTH; s++) begin
         sb_vld[s] = sb_ff[s].valid;
      end
   end

   `VSK_ASSERT_NEXT(a_skin_enters, sb_in.valid, sb_ff[0].valid)
   `VSK_ASSERT_NEXT(a_stall_holds, !adv, $stable(sb_vld))
   `VSK_ASSERT_IMPL(a_write_on_accept, bind_we || pose_we, req_valid && req_ready)

endmodule
